// File: design/filtered_line_editor_buffer_core_macros.svh
// Assertion macros for the line editor buffer core.
// Each macro checks one implication, sampled at the rising clock edge and
// held off while reset is asserted.
`ifndef FILTERED_LINE_EDITOR_BUFFER_CORE_MACROS_SVH
`define FILTERED_LINE_EDITOR_BUFFER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define FLB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
// Next-cycle implication.
`define FLB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define FLB_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FLB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/flb_pkg.sv
`timescale 1ns / 1ps
package flb_pkg;

    // Buffer and queue sizing
    localparam int MAX_LEN_DEFAULT     = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // Port field widths
    localparam int CHAR_W = 8;
    localparam int KEY_W  = 4;
    localparam int POS_W  = 7;
    localparam int OP_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_ENABLED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_B32_STRICT    = 1'd1;

    // Item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_KEY  = 1'b1;

    // Editing key codes
    localparam logic [KEY_W-1:0] KEY_BACKSPACE = 4'd0;
    localparam logic [KEY_W-1:0] KEY_DELETE    = 4'd1;
    localparam logic [KEY_W-1:0] KEY_LEFT      = 4'd2;
    localparam logic [KEY_W-1:0] KEY_RIGHT     = 4'd3;
    localparam logic [KEY_W-1:0] KEY_HOME      = 4'd4;
    localparam logic [KEY_W-1:0] KEY_END       = 4'd5;
    localparam logic [KEY_W-1:0] KEY_CLEAR     = 4'd6;
    localparam logic [KEY_W-1:0] KEY_PASTE     = 4'd7;
    localparam logic [KEY_W-1:0] KEY_SUBMIT    = 4'd8;

    // Character classes
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_2 = 8'h32;
    localparam logic [CHAR_W-1:0] CHAR_DIGIT_7 = 8'h37;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_FOLD    = 8'h20;

    // Back-end operation codes
    localparam logic [OP_W-1:0] OP_REJECT    = 4'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 4'd1;
    localparam logic [OP_W-1:0] OP_BACKSPACE = 4'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 4'd3;
    localparam logic [OP_W-1:0] OP_LEFT      = 4'd4;
    localparam logic [OP_W-1:0] OP_RIGHT     = 4'd5;
    localparam logic [OP_W-1:0] OP_HOME      = 4'd6;
    localparam logic [OP_W-1:0] OP_END       = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR     = 4'd8;
    localparam logic [OP_W-1:0] OP_PASTE     = 4'd9;
    localparam logic [OP_W-1:0] OP_SUBMIT    = 4'd10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
    } cmd_t;

endpackage

// File: design/filtered_line_editor_buffer_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_kind, s_char_code, s_key_code
// m_        out        m_valid/m_ready    m_accepted, m_text_len, m_cursor_at,
//                                         m_out_char, m_char_valid, m_last
// cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// An edit passes through the command queue and the output registers before
// its result shows; requests stream at one per cycle while m_ready holds.
// A submit of a non-empty line busies the back end while it reads the line out.
// Reset is synchronous on aresetn (active low): buffer empty, cursor at 0,
// configuration cleared; stored characters are not cleared.
// A stalled m_ channel fills the command queue and then drops s_ready.
`include "filtered_line_editor_buffer_core_macros.svh"
module filtered_line_editor_buffer_core #(
    parameter int MAX_LEN     = flb_pkg::MAX_LEN_DEFAULT,
    parameter int QUEUE_DEPTH = flb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [flb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [flb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_kind,
    input  logic [flb_pkg::CHAR_W-1:0]     s_char_code,
    input  logic [flb_pkg::KEY_W-1:0]      s_key_code,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_accepted,
    output logic [flb_pkg::POS_W-1:0]      m_text_len,
    output logic [flb_pkg::POS_W-1:0]      m_cursor_at,
    output logic [flb_pkg::CHAR_W-1:0]     m_out_char,
    output logic                           m_char_valid,
    output logic                           m_last
);

    // Configuration registers
    logic field_enabled_reg;
    logic b32_strict_reg;

    // Front to queue, queue to back
    logic          push_valid, push_ready;
    flb_pkg::cmd_t push_cmd;
    logic          pop_valid, pop_ready;
    flb_pkg::cmd_t pop_cmd;

    // Latch register writes; unknown indexes drop silently
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_enabled_reg <= 1'b0;
            b32_strict_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                flb_pkg::REG_FIELD_ENABLED: field_enabled_reg <= cfg_wdata[0];
                flb_pkg::REG_B32_STRICT:    b32_strict_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Front: classify each request into a back-end command
    flb_front u_front (
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_char_code   (s_char_code),
        .s_key_code    (s_key_code),
        .field_enabled (field_enabled_reg),
        .b32_strict    (b32_strict_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    // Hold classified commands while the back end is busy or stalled
    flb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (aclk),
        .rst_n      (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Back: edit the buffer, advance the cursor, stream out on submit
    flb_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk          (aclk),
        .rst_n        (aresetn),
        .cmd_valid    (pop_valid),
        .cmd_ready    (pop_ready),
        .cmd          (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_text_len   (m_text_len),
        .m_cursor_at  (m_cursor_at),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_last       (m_last)
    );

    // Cursor never passes the end, and the text never outgrows the buffer
    `FLB_ASSERT_IMPLIES(a_cursor_in_text, aclk, aresetn, m_valid, (m_cursor_at <= m_text_len) && (m_text_len <= flb_pkg::POS_W'(MAX_LEN)))
    // A read-out character only comes from a consumed submit
    `FLB_ASSERT_IMPLIES(a_char_needs_accept, aclk, aresetn, m_valid && m_char_valid, m_accepted)
    // Every result other than a read-out character closes its request
    `FLB_ASSERT_IMPLIES(a_single_is_last, aclk, aresetn, m_valid && !m_char_valid, m_last && (m_out_char == '0))

endmodule

// File: design/flb_front.sv
`timescale 1ns / 1ps
module flb_front (
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_kind,
    input  logic [flb_pkg::CHAR_W-1:0] s_char_code,
    input  logic [flb_pkg::KEY_W-1:0]  s_key_code,
    input  logic                       field_enabled,
    input  logic                       b32_strict,
    output logic                       push_valid,
    input  logic                       push_ready,
    output flb_pkg::cmd_t              push_cmd
);

    logic [flb_pkg::CHAR_W-1:0] folded;
    logic                       pass;
    logic [flb_pkg::OP_W-1:0]   key_op;

    assign s_ready    = push_ready;
    assign push_valid = s_valid;

    // Filter: in base32 mode fold lowercase and keep only the alphabet; else keep bytes from space up
    always_comb begin
        folded = s_char_code;
        if (b32_strict) begin
            if (s_char_code >= flb_pkg::CHAR_LOWER_A && s_char_code <= flb_pkg::CHAR_LOWER_Z) begin
                folded = s_char_code - flb_pkg::CASE_FOLD;
            end
            pass = (folded >= flb_pkg::CHAR_UPPER_A && folded <= flb_pkg::CHAR_UPPER_Z) ||
                   (folded >= flb_pkg::CHAR_DIGIT_2 && folded <= flb_pkg::CHAR_DIGIT_7);
        end else begin
            pass = (s_char_code >= flb_pkg::CHAR_SPACE);
        end
    end

    always_comb begin
        case (s_key_code)
            flb_pkg::KEY_BACKSPACE: key_op = flb_pkg::OP_BACKSPACE;
            flb_pkg::KEY_DELETE:    key_op = flb_pkg::OP_DELETE;
            flb_pkg::KEY_LEFT:      key_op = flb_pkg::OP_LEFT;
            flb_pkg::KEY_RIGHT:     key_op = flb_pkg::OP_RIGHT;
            flb_pkg::KEY_HOME:      key_op = flb_pkg::OP_HOME;
            flb_pkg::KEY_END:       key_op = flb_pkg::OP_END;
            flb_pkg::KEY_CLEAR:     key_op = flb_pkg::OP_CLEAR;
            flb_pkg::KEY_PASTE:     key_op = flb_pkg::OP_PASTE;
            flb_pkg::KEY_SUBMIT:    key_op = flb_pkg::OP_SUBMIT;
            default:                key_op = flb_pkg::OP_REJECT;
        endcase
    end

    always_comb begin
        push_cmd.ch = folded;
        if (!field_enabled) begin
            push_cmd.op = flb_pkg::OP_REJECT;
        end else if (s_kind == flb_pkg::KIND_KEY) begin
            push_cmd.op = key_op;
        end else if (pass) begin
            push_cmd.op = flb_pkg::OP_INSERT;
        end else begin
            push_cmd.op = flb_pkg::OP_REJECT;
        end
    end

endmodule

// File: design/flb_queue.sv
`timescale 1ns / 1ps
module flb_queue #(
    parameter int DEPTH = flb_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  flb_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output flb_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    flb_pkg::cmd_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: design/flb_back.sv
`timescale 1ns / 1ps
module flb_back #(
    parameter int MAX_LEN = flb_pkg::MAX_LEN_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  flb_pkg::cmd_t              cmd,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_accepted,
    output logic [flb_pkg::POS_W-1:0]  m_text_len,
    output logic [flb_pkg::POS_W-1:0]  m_cursor_at,
    output logic [flb_pkg::CHAR_W-1:0] m_out_char,
    output logic                       m_char_valid,
    output logic                       m_last
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    logic [flb_pkg::CHAR_W-1:0] slot_reg [MAX_LEN];
    logic [flb_pkg::CHAR_W-1:0] slot_next [MAX_LEN];
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] cur_reg, cur_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_acc_reg, out_acc_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic [LEN_W-1:0] out_cur_reg, out_cur_next;
    logic [flb_pkg::CHAR_W-1:0] out_char_reg, out_char_next;
    logic             out_cv_reg, out_cv_next;
    logic             out_last_reg, out_last_next;

    logic             out_free, take, step;
    logic             do_ins, do_rem, do_rot;
    logic [LEN_W-1:0] rem_pos;
    logic             read_last;

    assign out_free  = !out_valid_reg || m_ready;
    assign take      = cmd_valid && !busy_reg && out_free;
    assign step      = busy_reg && out_free;
    assign cmd_ready = take;
    assign read_last = (cnt_reg == len_reg - 1'b1);

    always_comb begin
        len_next       = len_reg;
        cur_next       = cur_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        do_ins         = 1'b0;
        do_rem         = 1'b0;
        do_rot         = 1'b0;
        rem_pos        = cur_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_acc_next   = out_acc_reg;
        out_len_next   = out_len_reg;
        out_cur_next   = out_cur_reg;
        out_char_next  = out_char_reg;
        out_cv_next    = out_cv_reg;
        out_last_next  = out_last_reg;
        if (step) begin
            // Readout: show slot 0, rotate the text by one place
            do_rot         = 1'b1;
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
            out_acc_next   = 1'b1;
            out_len_next   = len_reg;
            out_cur_next   = cur_reg;
            out_char_next  = slot_reg[0];
            out_cv_next    = 1'b1;
            out_last_next  = read_last;
            if (read_last) begin
                busy_next = 1'b0;
            end
        end else if (take) begin
            out_valid_next = 1'b1;
            out_acc_next   = 1'b1;
            out_char_next  = '0;
            out_cv_next    = 1'b0;
            out_last_next  = 1'b1;
            case (cmd.op)
                flb_pkg::OP_INSERT: begin
                    if (len_reg < LEN_W'(MAX_LEN)) begin
                        do_ins   = 1'b1;
                        len_next = len_reg + 1'b1;
                        cur_next = cur_reg + 1'b1;
                    end else begin
                        out_acc_next = 1'b0;
                    end
                end
                flb_pkg::OP_BACKSPACE: begin
                    rem_pos = cur_reg - 1'b1;
                    if (cur_reg != '0) begin
                        do_rem   = 1'b1;
                        len_next = len_reg - 1'b1;
                        cur_next = cur_reg - 1'b1;
                    end
                end
                flb_pkg::OP_DELETE: begin
                    if (cur_reg < len_reg) begin
                        do_rem   = 1'b1;
                        len_next = len_reg - 1'b1;
                    end
                end
                flb_pkg::OP_LEFT: begin
                    if (cur_reg != '0) begin
                        cur_next = cur_reg - 1'b1;
                    end
                end
                flb_pkg::OP_RIGHT: begin
                    if (cur_reg < len_reg) begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
                flb_pkg::OP_HOME: cur_next = '0;
                flb_pkg::OP_END:  cur_next = len_reg;
                flb_pkg::OP_CLEAR: begin
                    len_next = '0;
                    cur_next = '0;
                end
                flb_pkg::OP_PASTE: begin
                end
                flb_pkg::OP_SUBMIT: begin
                    if (len_reg != '0) begin
                        out_valid_next = 1'b0;
                        busy_next      = 1'b1;
                        cnt_next       = '0;
                    end
                end
                default: out_acc_next = 1'b0;
            endcase
            out_len_next = len_next;
            out_cur_next = cur_next;
        end
    end

    // One slot per character, each with fixed neighbors
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_slot
        logic [flb_pkg::CHAR_W-1:0] prev_char, next_char;
        if (i > 0) begin : g_prev
            assign prev_char = slot_reg[i-1];
        end else begin : g_first
            assign prev_char = slot_reg[i];
        end
        if (i < MAX_LEN - 1) begin : g_next
            assign next_char = slot_reg[i+1];
        end else begin : g_final
            assign next_char = slot_reg[i];
        end

        always_comb begin
            slot_next[i] = slot_reg[i];
            if (do_ins) begin
                if (LEN_W'(i) == cur_reg) begin
                    slot_next[i] = cmd.ch;
                end else if (LEN_W'(i) > cur_reg) begin
                    slot_next[i] = prev_char;
                end
            end else if (do_rem) begin
                if (LEN_W'(i) >= rem_pos) begin
                    slot_next[i] = next_char;
                end
            end else if (do_rot) begin
                if (LEN_W'(i + 1) == len_reg) begin
                    slot_next[i] = slot_reg[0];
                end else if (LEN_W'(i + 1) < len_reg) begin
                    slot_next[i] = next_char;
                end
            end
        end

        always_ff @(posedge clk) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            len_reg       <= '0;
            cur_reg       <= '0;
            cnt_reg       <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg       <= len_next;
            cur_reg       <= cur_next;
            cnt_reg       <= cnt_next;
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        out_acc_reg  <= out_acc_next;
        out_len_reg  <= out_len_next;
        out_cur_reg  <= out_cur_next;
        out_char_reg <= out_char_next;
        out_cv_reg   <= out_cv_next;
        out_last_reg <= out_last_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_accepted   = out_acc_reg;
    assign m_text_len   = flb_pkg::POS_W'(out_len_reg);
    assign m_cursor_at  = flb_pkg::POS_W'(out_cur_reg);
    assign m_out_char   = out_char_reg;
    assign m_char_valid = out_cv_reg;
    assign m_last       = out_last_reg;

endmodule

// File: verif/tb_filtered_line_editor_buffer_core.sv
`timescale 1ns / 1ps
module tb_filtered_line_editor_buffer_core;
    import flb_pkg::*;

    localparam int TEXT_CAP       = MAX_LEN_DEFAULT;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [KEY_W-1:0] KEY_CODE_TOP = '1;

    typedef struct {
        logic              kind;
        logic [CHAR_W-1:0] char_code;
        logic [KEY_W-1:0]  key_code;
    } keystroke_t;

    typedef struct {
        logic              accepted;
        logic [POS_W-1:0]  text_len;
        logic [POS_W-1:0]  cursor_at;
        logic [CHAR_W-1:0] out_char;
        logic              char_valid;
        logic              last;
    } edit_outcome_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [CHAR_W-1:0]     s_char_code;
    logic [KEY_W-1:0]      s_key_code;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_accepted;
    logic [POS_W-1:0]      m_text_len;
    logic [POS_W-1:0]      m_cursor_at;
    logic [CHAR_W-1:0]     m_out_char;
    logic                  m_char_valid;
    logic                  m_last;

    // Requests waiting to go out, and the results the shadow editor predicts.
    keystroke_t    keystroke_q[$];
    edit_outcome_t editor_outcomes_q[$];

    // Shadow copy of the editor: text, length, cursor and both settings.
    logic [CHAR_W-1:0] shadow_text [TEXT_CAP];
    logic [POS_W-1:0]  shadow_len;
    logic [POS_W-1:0]  shadow_cursor;
    bit                shadow_enabled;
    bit                shadow_base32;

    bit no_idle;
    int mismatches;
    int idle_cycles;

    filtered_line_editor_buffer_core DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_char_code  (s_char_code),
        .s_key_code   (s_key_code),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_accepted   (m_accepted),
        .m_text_len   (m_text_len),
        .m_cursor_at  (m_cursor_at),
        .m_out_char   (m_out_char),
        .m_char_valid (m_char_valid),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shadow editor
    // ------------------------------------------------------------------

    // Fold and screen one typed byte under the current alphabet setting.
    function automatic bit char_passes(input logic [CHAR_W-1:0] raw,
                                       output logic [CHAR_W-1:0] folded);
        folded = raw;
        if (shadow_base32) begin
            if (raw >= CHAR_LOWER_A && raw <= CHAR_LOWER_Z)
                folded = raw - CASE_FOLD;
            return (folded >= CHAR_UPPER_A && folded <= CHAR_UPPER_Z) ||
                   (folded >= CHAR_DIGIT_2 && folded <= CHAR_DIGIT_7);
        end
        return raw >= CHAR_SPACE;
    endfunction

    // Record one result; length and cursor are taken after the edit.
    task automatic push_outcome(input logic acc, input logic [CHAR_W-1:0] ch,
                                input logic ch_valid, input logic fin);
        edit_outcome_t o;
        o.accepted   = acc;
        o.text_len   = shadow_len;
        o.cursor_at  = shadow_cursor;
        o.out_char   = ch;
        o.char_valid = ch_valid;
        o.last       = fin;
        editor_outcomes_q.push_back(o);
    endtask

    // Apply one accepted request to the shadow editor and queue its results.
    task automatic apply_edit(input keystroke_t ks);
        logic [CHAR_W-1:0] folded;
        logic              acc;
        int                i;
        // A disabled field answers every request with a bare rejection.
        if (!shadow_enabled) begin
            push_outcome(1'b0, '0, 1'b0, 1'b1);
            return;
        end
        if (ks.kind == KIND_CHAR) begin
            acc = 1'b0;
            if (shadow_len < TEXT_CAP && char_passes(ks.char_code, folded)) begin
                // Open a slot at the cursor: shift the tail right by one.
                for (i = shadow_len; i > shadow_cursor; i--)
                    shadow_text[i] = shadow_text[i-1];
                shadow_text[shadow_cursor] = folded;
                shadow_cursor = shadow_cursor + 1'b1;
                shadow_len    = shadow_len + 1'b1;
                acc = 1'b1;
            end
            push_outcome(acc, '0, 1'b0, 1'b1);
            return;
        end
        acc = 1'b1;
        case (ks.key_code)
            KEY_BACKSPACE: begin
                if (shadow_cursor > 0) begin
                    for (i = shadow_cursor; i < shadow_len; i++)
                        shadow_text[i-1] = shadow_text[i];
                    shadow_cursor = shadow_cursor - 1'b1;
                    shadow_len    = shadow_len - 1'b1;
                end
            end
            KEY_DELETE: begin
                if (shadow_cursor < shadow_len) begin
                    for (i = shadow_cursor; i + 1 < shadow_len; i++)
                        shadow_text[i] = shadow_text[i+1];
                    shadow_len = shadow_len - 1'b1;
                end
            end
            KEY_LEFT: begin
                if (shadow_cursor > 0)
                    shadow_cursor = shadow_cursor - 1'b1;
            end
            KEY_RIGHT: begin
                if (shadow_cursor < shadow_len)
                    shadow_cursor = shadow_cursor + 1'b1;
            end
            KEY_HOME:  shadow_cursor = '0;
            KEY_END:   shadow_cursor = shadow_len;
            KEY_CLEAR: begin
                shadow_len    = '0;
                shadow_cursor = '0;
            end
            KEY_PASTE: ;
            KEY_SUBMIT: begin
                // Read the whole line out; an empty line still answers once.
                if (shadow_len == 0) begin
                    push_outcome(1'b1, '0, 1'b0, 1'b1);
                end else begin
                    for (i = 0; i < shadow_len; i++)
                        push_outcome(1'b1, shadow_text[i], 1'b1, i + 1 == shadow_len);
                end
                return;
            end
            default: acc = 1'b0;
        endcase
        push_outcome(acc, '0, 1'b0, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic keystroke_t char_req(input logic [CHAR_W-1:0] c);
        keystroke_t ks;
        ks.kind      = KIND_CHAR;
        ks.char_code = c;
        ks.key_code  = KEY_W'($urandom_range(0, KEY_CODE_TOP));
        return ks;
    endfunction

    function automatic keystroke_t key_req(input logic [KEY_W-1:0] k);
        keystroke_t ks;
        ks.kind      = KIND_KEY;
        ks.char_code = CHAR_W'($urandom_range(0, 255));
        ks.key_code  = k;
        return ks;
    endfunction

    // Pick a character that the current alphabet lets through.
    function automatic logic [CHAR_W-1:0] typical_char(input bit b32);
        if (!b32)
            return CHAR_W'(CHAR_SPACE + $urandom_range(0, 8'h5E));
        case ($urandom_range(0, 2))
            0:       return CHAR_W'(CHAR_UPPER_A + $urandom_range(0, 25));
            1:       return CHAR_W'(CHAR_LOWER_A + $urandom_range(0, 25));
            default: return CHAR_W'(CHAR_DIGIT_2 + $urandom_range(0, 5));
        endcase
    endfunction

    // Mostly sensible typing and editing, with raw bytes and bad keys mixed in.
    function automatic keystroke_t random_req(input bit b32);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return char_req(typical_char(b32));
        if (pick < 55)
            return char_req(CHAR_W'($urandom_range(0, 255)));
        if (pick < 95)
            return key_req(KEY_W'($urandom_range(KEY_BACKSPACE, KEY_SUBMIT)));
        return key_req(KEY_W'($urandom_range(KEY_SUBMIT + 1, KEY_CODE_TOP)));
    endfunction

    // Type past the capacity, read the full line, then poke at a full buffer.
    task automatic queue_fill_burst(input bit b32);
        repeat (TEXT_CAP + 3) keystroke_q.push_back(char_req(typical_char(b32)));
        keystroke_q.push_back(key_req(KEY_SUBMIT));
        keystroke_q.push_back(key_req(KEY_HOME));
        keystroke_q.push_back(char_req(typical_char(b32)));
        keystroke_q.push_back(key_req(KEY_DELETE));
        keystroke_q.push_back(key_req(KEY_END));
        keystroke_q.push_back(key_req(KEY_BACKSPACE));
    endtask

    task automatic queue_random(input int count, input bit b32);
        repeat (count) keystroke_q.push_back(random_req(b32));
    endtask

    // Write one register; only called with nothing in flight.
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx, input bit val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_FIELD_ENABLED: shadow_enabled = val;
            REG_B32_STRICT:    shadow_base32  = val;
            default: ;
        endcase
    endtask

    // Wait until every request is sent and answered, then let the pipe settle.
    // Sample at the falling edge so that all updates of the rising edge are in.
    task automatic drain();
        do @(negedge aclk);
        while (keystroke_q.size() != 0 || s_valid || editor_outcomes_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : request_driver
        static keystroke_t on_bus;
        static int         src_gap = 0;
        static int         src_run = 0;
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
            src_run = 0;
        end else begin
            // Predict at the edge where the request is taken.
            if (s_valid && s_ready)
                apply_edit(on_bus);
            if (s_valid && !s_ready) begin
                // Hold the request until it is taken.
            end else if (src_gap != 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (keystroke_q.size() != 0 && !no_idle && src_run == 0 &&
                         $urandom_range(0, 1) == 0) begin
                // Drop valid for a random gap, then send a random run of requests.
                src_gap = $urandom_range(0, 7);
                src_run = $urandom_range(1, 16);
                s_valid <= 1'b0;
            end else if (keystroke_q.size() != 0) begin
                if (src_run != 0)
                    src_run--;
                on_bus = keystroke_q.pop_front();
                s_valid     <= 1'b1;
                s_kind      <= on_bus.kind;
                s_char_code <= on_bus.char_code;
                s_key_code  <= on_bus.key_code;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        static int     sink_gap = 0;
        edit_outcome_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (editor_outcomes_q.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatches++;
                end else begin
                    want = editor_outcomes_q.pop_front();
                    check_field("accepted",   want.accepted,   m_accepted);
                    check_field("text_len",   want.text_len,   m_text_len);
                    check_field("cursor_at",  want.cursor_at,  m_cursor_at);
                    check_field("out_char",   want.out_char,   m_out_char);
                    check_field("char_valid", want.char_valid, m_char_valid);
                    check_field("last",       want.last,       m_last);
                end
            end
            // Stall the result channel now and then, for a random gap.
            if (sink_gap != 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                sink_gap = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Advance a counter on every cycle in which nothing moves; stop on a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_filtered_line_editor_buffer_core: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_kind         = KIND_CHAR;
        s_char_code    = '0;
        s_key_code     = KEY_BACKSPACE;
        m_ready        = 1'b0;
        no_idle        = 1'b0;
        mismatches     = 0;
        idle_cycles    = 0;
        shadow_len     = '0;
        shadow_cursor  = '0;
        shadow_enabled = 1'b0;
        shadow_base32  = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Field still disabled out of reset: everything is turned away.
        keystroke_q.push_back(char_req(CHAR_UPPER_A));
        keystroke_q.push_back(key_req(KEY_SUBMIT));
        drain();

        write_setting(REG_FIELD_ENABLED, 1'b1);
        write_setting(REG_B32_STRICT, 1'b0);

        // Edges of an empty line, control bytes, the byte extremes and every key.
        keystroke_q.push_back(key_req(KEY_SUBMIT));
        keystroke_q.push_back(key_req(KEY_BACKSPACE));
        keystroke_q.push_back(key_req(KEY_DELETE));
        keystroke_q.push_back(key_req(KEY_LEFT));
        keystroke_q.push_back(key_req(KEY_RIGHT));
        keystroke_q.push_back(char_req(8'h00));
        keystroke_q.push_back(char_req(CHAR_SPACE - 1'b1));
        keystroke_q.push_back(char_req(CHAR_SPACE));
        keystroke_q.push_back(char_req(8'hFF));
        keystroke_q.push_back(key_req(KEY_HOME));
        keystroke_q.push_back(char_req(8'h7E));
        keystroke_q.push_back(key_req(KEY_END));
        keystroke_q.push_back(key_req(KEY_PASTE));
        keystroke_q.push_back(key_req(KEY_CODE_TOP));
        keystroke_q.push_back(key_req(KEY_SUBMIT));
        keystroke_q.push_back(key_req(KEY_CLEAR));
        drain();

        // Base32 alphabet: case folding, the bytes just outside the digit and uppercase ranges, and the byte after z.
        write_setting(REG_B32_STRICT, 1'b1);
        keystroke_q.push_back(char_req(CHAR_LOWER_A));
        keystroke_q.push_back(char_req(CHAR_LOWER_Z));
        keystroke_q.push_back(char_req(CHAR_DIGIT_2));
        keystroke_q.push_back(char_req(CHAR_DIGIT_7));
        keystroke_q.push_back(char_req(CHAR_DIGIT_2 - 1'b1));
        keystroke_q.push_back(char_req(CHAR_DIGIT_7 + 1'b1));
        keystroke_q.push_back(char_req(CHAR_UPPER_A - 1'b1));
        keystroke_q.push_back(char_req(CHAR_UPPER_Z + 1'b1));
        keystroke_q.push_back(char_req(CHAR_LOWER_Z + 1'b1));
        keystroke_q.push_back(key_req(KEY_SUBMIT));
        drain();

        // Random editing with the base32 alphabet.
        queue_fill_burst(1'b1);
        queue_random(80, 1'b1);
        drain();

        // Random editing with the plain alphabet.
        write_setting(REG_B32_STRICT, 1'b0);
        queue_fill_burst(1'b0);
        queue_random(80, 1'b0);
        drain();

        // Disable the field mid-session; the line must survive untouched.
        write_setting(REG_FIELD_ENABLED, 1'b0);
        write_setting(REG_B32_STRICT, 1'b1);
        queue_random(10, 1'b1);
        drain();

        // Final stretch at full rate on both channels.
        write_setting(REG_FIELD_ENABLED, 1'b1);
        write_setting(REG_B32_STRICT, 1'b0);
        no_idle = 1'b1;
        queue_random(80, 1'b0);
        keystroke_q.push_back(key_req(KEY_SUBMIT));
        drain();

        if (mismatches == 0) begin
            $display("tb_filtered_line_editor_buffer_core: clean");
        end else begin
            $display("tb_filtered_line_editor_buffer_core: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/flb_pkg.sv
design/flb_front.sv
design/flb_queue.sv
design/flb_back.sv
design/filtered_line_editor_buffer_core.sv
verif/tb_filtered_line_editor_buffer_core.sv
